// ===== hdl/diug_pkg.sv =====
// Package with shared types and constants of the interval union gain block.
package diug_pkg;
	localparam int MaxSegmentsDefault = 64;
	localparam int CoordBitsDefault = 32;
	localparam int GainBits = 32;
	localparam int CountBits = 7;

	typedef struct packed {
		logic [31:0] seg_start;
		logic [31:0] seg_end;
	} in_word_t;

	typedef struct packed {
		logic [GainBits-1:0] gain;
		logic table_full;
		logic [CountBits-1:0] entry_count;
	} out_word_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;     // capture input word, clear accumulators
		logic rd;       // issue read of entry at read index
		logic scan;     // accumulate gain from registered read data
		logic merge;    // merge/compact with registered read data
		logic rst_idx;  // clear read/write indexes
		logic finish;   // write union entry and form result
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic last_rd;  // read index has reached the count
		logic covered;
		logic any_meet;
		logic full;     // count is at capacity
	} dp_sts_t;
endpackage

// ===== hdl/disjoint_interval_union_gain_top.sv =====
// Top level of the disjoint interval union gain block.
//   channel | dir | handshake           | word
//   in      | in  | in_valid/in_ready   | in_word  (seg_start, seg_end)
//   out     | out | out_valid/out_ready | out_word (gain, table_full, entry_count)
// An item passes through acceptance, a gain pass and a merge pass through the single read port,
// the finish step and then the held result. A covered or dropped word skips the merge
// pass. Reset clears the count; table contents need no clearing.
// One word is worked at a time; the result is held until out_ready.
module disjoint_interval_union_gain_top #(
	parameter int MAX_SEGMENTS = diug_pkg::MaxSegmentsDefault,
	parameter int COORD_BITS = diug_pkg::CoordBitsDefault
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input diug_pkg::in_word_t in_word,
	output logic out_valid,
	input logic out_ready,
	output diug_pkg::out_word_t out_word
);
	import diug_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	diug_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	diug_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS), .COORD_BITS(COORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_word(in_word),
		.cmd(cmd), .sts(sts), .result(out_word)
	);
endmodule

// ===== hdl/diug_datapath.sv =====
// Datapath: segment table memory, overlap accumulation and compaction.
module diug_datapath #(
	parameter int MAX_SEGMENTS = diug_pkg::MaxSegmentsDefault,
	parameter int COORD_BITS = diug_pkg::CoordBitsDefault
) (
	input logic clk,
	input logic arst_n,
	input diug_pkg::in_word_t in_word,
	input diug_pkg::dp_cmd_t cmd,
	output diug_pkg::dp_sts_t sts,
	output diug_pkg::out_word_t result
);
	import diug_pkg::*;

	localparam int IdxBits = $clog2(MAX_SEGMENTS);
	localparam int CntBits = $clog2(MAX_SEGMENTS + 1);
	localparam int AccBits = COORD_BITS + 1;

	logic [COORD_BITS-1:0] mem_start [MAX_SEGMENTS];
	logic [COORD_BITS-1:0] mem_end [MAX_SEGMENTS];
	logic [COORD_BITS-1:0] rd_start_q, rd_end_q;
	logic [COORD_BITS-1:0] s_q, e_q, us_q, ue_q;
	logic [AccBits-1:0] overlap_q;
	logic [CntBits-1:0] count_q, ridx_q, widx_q;
	logic covered_q, meet_q;
	logic [COORD_BITS-1:0] s_in, e_in, lo, hi, wr_s, wr_e;
	logic meets, covers, wr_en;
	logic do_store;
	logic [IdxBits-1:0] wr_addr;
	logic [COORD_BITS-1:0] len;
	logic [AccBits-1:0] gain_w;
	logic [CntBits-1:0] new_count;

	assign s_in = COORD_BITS'(in_word.seg_start);
	assign e_in = (COORD_BITS'(in_word.seg_end) < s_in) ? s_in : COORD_BITS'(in_word.seg_end);
	assign meets = (rd_start_q <= e_q) && (rd_end_q >= s_q);
	assign covers = (rd_start_q <= s_q) && (rd_end_q >= e_q);
	assign lo = (rd_start_q > s_q) ? rd_start_q : s_q;
	assign hi = (rd_end_q < e_q) ? rd_end_q : e_q;
	assign len = e_q - s_q;
	assign gain_w = (covered_q || overlap_q > AccBits'(len)) ? '0 : AccBits'(len) - overlap_q;

	// The union is stored unless the word is covered or the table is full with no meet.
	assign do_store = !covered_q && (meet_q || !sts.full);

	// Kept entries slide down to the write index; the union lands after them.
	assign wr_en = (cmd.merge && !meets) ||
		(cmd.finish && do_store && widx_q < CntBits'(MAX_SEGMENTS));
	assign wr_addr = widx_q[IdxBits-1:0];
	assign wr_s = cmd.finish ? us_q : rd_start_q;
	assign wr_e = cmd.finish ? ue_q : rd_end_q;
	assign new_count = (widx_q < CntBits'(MAX_SEGMENTS)) ? widx_q + 1'b1 : widx_q;

	assign sts.last_rd = (ridx_q == count_q);
	assign sts.covered = covered_q;
	assign sts.any_meet = meet_q;
	assign sts.full = (count_q == CntBits'(MAX_SEGMENTS));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_start[wr_addr] <= wr_s;
			mem_end[wr_addr] <= wr_e;
		end
		if (cmd.rd) begin
			rd_start_q <= mem_start[ridx_q[IdxBits-1:0]];
			rd_end_q <= mem_end[ridx_q[IdxBits-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ridx_q <= '0;
			widx_q <= '0;
			covered_q <= 1'b0;
			meet_q <= 1'b0;
			overlap_q <= '0;
			s_q <= '0;
			e_q <= '0;
			us_q <= '0;
			ue_q <= '0;
			result <= '0;
		end else begin
			if (cmd.load) begin
				s_q <= s_in;
				e_q <= e_in;
				us_q <= s_in;
				ue_q <= e_in;
				covered_q <= 1'b0;
				meet_q <= 1'b0;
				overlap_q <= '0;
			end
			if (cmd.rst_idx) begin
				ridx_q <= '0;
				widx_q <= '0;
			end else if (cmd.rd) begin
				ridx_q <= ridx_q + 1'b1;
			end
			if (cmd.scan) begin
				if (covers) covered_q <= 1'b1;
				if (meets) begin
					meet_q <= 1'b1;
					if (hi > lo) overlap_q <= overlap_q + AccBits'(hi - lo);
				end
			end
			if (cmd.merge) begin
				if (meets) begin
					if (rd_start_q < us_q) us_q <= rd_start_q;
					if (rd_end_q > ue_q) ue_q <= rd_end_q;
				end else begin
					widx_q <= widx_q + 1'b1;
				end
			end
			if (cmd.finish) begin
				result.gain <= GainBits'(gain_w);
				result.entry_count <= CountBits'(count_q);
				result.table_full <= 1'b0;
				if (covered_q) begin
				end else if (!meet_q && sts.full) begin
					result.table_full <= 1'b1;
				end else begin
					count_q <= new_count;
					result.entry_count <= CountBits'(new_count);
				end
			end
		end
	end
endmodule

// ===== hdl/diug_ctrl.sv =====
// Controller: sequences the gain pass, merge pass and result handshake.
module diug_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input diug_pkg::dp_sts_t sts,
	output diug_pkg::dp_cmd_t cmd
);
	import diug_pkg::*;

	typedef enum logic [2:0] {
		IDLE, SCAN_RD, SCAN_USE, MERGE_RD, MERGE_USE, FINISH, DONE
	} state_t;
	state_t state_q;

	assign in_ready = (state_q == IDLE);
	assign out_valid = (state_q == DONE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			IDLE: begin
				cmd.load = in_valid;
				cmd.rst_idx = 1'b1;
			end
			SCAN_RD: begin
				cmd.rd = !sts.last_rd;
				// The merge pass starts fresh from entry zero after the gain pass.
				cmd.rst_idx = sts.last_rd;
			end
			SCAN_USE: cmd.scan = 1'b1;
			MERGE_RD: cmd.rd = !sts.last_rd;
			MERGE_USE: cmd.merge = 1'b1;
			FINISH: cmd.finish = 1'b1;
			DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: if (in_valid) state_q <= SCAN_RD;
				SCAN_RD: state_q <= sts.last_rd ? MERGE_RD : SCAN_USE;
				SCAN_USE: state_q <= SCAN_RD;
				MERGE_RD: begin
					if (sts.last_rd || sts.covered || (!sts.any_meet && sts.full))
						state_q <= FINISH;
					else
						state_q <= MERGE_USE;
				end
				MERGE_USE: state_q <= MERGE_RD;
				FINISH: state_q <= DONE;
				DONE: if (out_ready) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

// ===== bench/tb_top.sv =====
// Testbench for the disjoint interval union gain block: random and directed segments.
`timescale 1ns / 1ps

module tb_top;
	import diug_pkg::*;

	localparam int TableDepth = MaxSegmentsDefault;
	localparam int CycleLimit = 1500000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_word_t in_word;
	logic out_valid;
	logic out_ready;
	out_word_t out_word;

	disjoint_interval_union_gain_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

	// Shadow copy of the coverage table.
	logic [31:0] cov_start [TableDepth];
	logic [31:0] cov_end [TableDepth];
	int cov_count;

	in_word_t pending_segs[$];
	out_word_t expected_gains[$];
	int mismatches;
	int cycles;
	bit quiet_phase;

	function automatic out_word_t merge_segment(in_word_t w);
		logic [31:0] s, e, us, ue;
		logic [32:0] overlap, len, lo, hi;
		bit covered, any_meet;
		int wr;
		out_word_t r;
		s = w.seg_start;
		e = (w.seg_end < s) ? s : w.seg_end;
		len = e - s;
		overlap = 0;
		covered = 0;
		any_meet = 0;
		for (int i = 0; i < cov_count; i++) begin
			if (cov_start[i] <= s && cov_end[i] >= e)
				covered = 1;
			if (cov_start[i] <= e && cov_end[i] >= s) begin
				any_meet = 1;
				lo = (cov_start[i] > s) ? cov_start[i] : s;
				hi = (cov_end[i] < e) ? cov_end[i] : e;
				if (hi > lo)
					overlap += hi - lo;
			end
		end
		r.gain = (covered || overlap > len) ? 32'd0 : 32'(len - overlap);
		r.table_full = 0;
		if (!covered) begin
			if (!any_meet && cov_count >= TableDepth) begin
				r.table_full = 1;
			end else begin
				us = s;
				ue = e;
				wr = 0;
				for (int i = 0; i < cov_count; i++) begin
					if (cov_start[i] <= e && cov_end[i] >= s) begin
						if (cov_start[i] < us)
							us = cov_start[i];
						if (cov_end[i] > ue)
							ue = cov_end[i];
					end else begin
						cov_start[wr] = cov_start[i];
						cov_end[wr] = cov_end[i];
						wr++;
					end
				end
				if (wr < TableDepth) begin
					cov_start[wr] = us;
					cov_end[wr] = ue;
					wr++;
				end
				cov_count = wr;
			end
		end
		r.entry_count = CountBits'(cov_count);
		return r;
	endfunction

	function automatic in_word_t make_seg(logic [31:0] s, logic [31:0] e);
		in_word_t w;
		w.seg_start = s;
		w.seg_end = e;
		return w;
	endfunction

	task automatic add_seg(logic [31:0] s, logic [31:0] e);
		pending_segs = {pending_segs, make_seg(s, e)};
	endtask

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_word <= '0;
		end else begin
			if (in_valid && in_ready)
				expected_gains = {expected_gains, merge_segment(in_word)};
			if (!in_valid || in_ready) begin
				if (pending_segs.size() > 0 && (quiet_phase || $urandom_range(99) >= 31)) begin
					in_valid <= 1;
					in_word <= pending_segs.pop_front();
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// Monitor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			out_ready <= quiet_phase || $urandom_range(99) >= 31;
			if (out_valid && out_ready) begin
				if (expected_gains.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word %p", out_word);
				end else begin
					out_word_t exp_w;
					exp_w = expected_gains.pop_front();
					if (exp_w !== out_word) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp gain %h full %b count %0d, ",
								"got gain %h full %b count %0d"},
								exp_w.gain, exp_w.table_full, exp_w.entry_count,
								out_word.gain, out_word.table_full, out_word.entry_count);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("** disjoint_interval_union_gain_top: FAILED **");
			$finish;
		end
	end

	initial begin
		logic [31:0] s;
		mismatches = 0;
		cycles = 0;
		cov_count = 0;
		quiet_phase = 0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		// Directed: zero length, top of range, end below start, touching, covered.
		add_seg(32'h0, 32'h0);
		add_seg(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_seg(32'h1000, 32'h10);
		add_seg(32'h100, 32'h200);
		add_seg(32'h200, 32'h300);
		add_seg(32'h50, 32'h100);
		add_seg(32'h150, 32'h180);
		add_seg(32'h0, 32'h1);
		// Short segments spread over the range fill the table and then hit it full.
		for (int i = 0; i < 450; i++) begin
			s = $urandom;
			add_seg(s, s + 32'($urandom_range(4096)));
		end
		add_seg(32'h5555_5555, 32'hAAAA_AAAA);
		// Longer segments swallow runs of stored entries.
		for (int i = 0; i < 400; i++) begin
			s = $urandom;
			add_seg(s, s + 32'($urandom_range(32'h0400_0000)));
		end
		for (int i = 0; i < 90; i++)
			add_seg($urandom, $urandom);
		// The whole range covers everything that follows it.
		add_seg(32'h0, 32'hFFFF_FFFF);
		add_seg(32'h1234, 32'h5678);
		add_seg(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		wait (pending_segs.size() < 600);
		quiet_phase = 1;
		wait (pending_segs.size() < 300);
		quiet_phase = 0;
		wait (pending_segs.size() == 0 && !in_valid);
		wait (expected_gains.size() == 0);
		repeat (400) @(posedge clk);
		if (mismatches == 0)
			$display("** disjoint_interval_union_gain_top: PASSED **");
		else
			$display("** disjoint_interval_union_gain_top: FAILED **");
		$finish;
	end
endmodule
